// File: sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with active-low reset disable
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form on top of the plain one
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_AT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// File: sv/mipb_pkg.sv
`default_nettype none
package mipb_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned ProdW = 2 * WordW;
  localparam int unsigned HalfW = WordW / 2;
  localparam int unsigned AddrW = 5;
  localparam int unsigned RegIdxW = 2;
  localparam int unsigned RegLsb = 3;

  localparam logic [RegIdxW-1:0] RegModulus  = 2'd0;
  localparam logic [RegIdxW-1:0] RegRatioLow = 2'd1;
  localparam logic [RegIdxW-1:0] RegRatioHigh = 2'd2;

  typedef enum logic [2:0] {
    MulAB,
    MulZ0RatioLow,
    MulZ0RatioHigh,
    MulZ1RatioLow,
    MulZ1RatioHigh,
    MulQuotMod
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    mul_sel_e mul_sel;
    logic     cap_z;
    logic     cap_carry1;
    logic     cap_acc;
    logic     cap_carry2;
    logic     cap_quot;
    logic     cap_rem;
    logic     cap_red;
    logic     acc_en;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// File: sv/mipb_ifs.sv
`default_nettype none
interface mipb_in_if #(
  parameter int unsigned MODULUS_BITS = 61
);
  logic                    valid;
  logic                    ready;
  logic [MODULUS_BITS-1:0] left_value;
  logic [MODULUS_BITS-1:0] right_value;
  logic                    last_pair;

  modport source (output valid, left_value, right_value, last_pair, input ready);
  modport sink (input valid, left_value, right_value, last_pair, output ready);
endinterface

interface mipb_out_if #(
  parameter int unsigned MODULUS_BITS = 61
);
  logic                    valid;
  logic                    ready;
  logic [MODULUS_BITS-1:0] dot_sum;

  modport source (output valid, dot_sum, input ready);
  modport sink (input valid, dot_sum, output ready);
endinterface
`default_nettype wire

// File: sv/mipb_regs.sv
`default_nettype none
module mipb_regs #(
  parameter int unsigned MODULUS_BITS = 61
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mipb_pkg::AddrW-1:0]    paddr,
  input  wire logic [mipb_pkg::WordW-1:0]    pwdata,
  output logic      [mipb_pkg::WordW-1:0]    prdata,
  output logic                               pready,
  output logic      [MODULUS_BITS-1:0]       modulus_o,
  output logic      [mipb_pkg::WordW-1:0]    ratio_low_o,
  output logic      [mipb_pkg::WordW-1:0]    ratio_high_o
);

  logic [MODULUS_BITS-1:0]       modulus_q;
  logic [mipb_pkg::WordW-1:0]    ratio_low_q;
  logic [mipb_pkg::WordW-1:0]    ratio_high_q;
  logic [mipb_pkg::RegIdxW-1:0]  reg_idx;
  logic                          wr_en;

  assign reg_idx = paddr[mipb_pkg::AddrW-1:mipb_pkg::RegLsb];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q    <= MODULUS_BITS'(2);
      ratio_low_q  <= '0;
      ratio_high_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        mipb_pkg::RegModulus:   modulus_q    <= pwdata[MODULUS_BITS-1:0];
        mipb_pkg::RegRatioLow:  ratio_low_q  <= pwdata;
        mipb_pkg::RegRatioHigh: ratio_high_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mipb_pkg::RegModulus:   prdata = mipb_pkg::WordW'(modulus_q);
      mipb_pkg::RegRatioLow:  prdata = ratio_low_q;
      mipb_pkg::RegRatioHigh: prdata = ratio_high_q;
      default:                prdata = '0;
    endcase
  end

  assign modulus_o    = modulus_q;
  assign ratio_low_o  = ratio_low_q;
  assign ratio_high_o = ratio_high_q;

endmodule
`default_nettype wire

// File: sv/mipb_mul.sv
`default_nettype none
module mipb_mul (
  input  wire logic                         clk_i,
  input  wire logic [mipb_pkg::WordW-1:0]   op_a_i,
  input  wire logic [mipb_pkg::WordW-1:0]   op_b_i,
  output logic      [mipb_pkg::ProdW-1:0]   prod_o
);

  localparam int unsigned H = mipb_pkg::HalfW;
  localparam int unsigned W = mipb_pkg::WordW;
  localparam int unsigned P = mipb_pkg::ProdW;

  logic [W-1:0] pp00_q, pp01_q, pp10_q, pp11_q;
  logic [P-1:0] prod_q;

  // stage one: four 32x32 partial products
  always_ff @(posedge clk_i) begin
    pp00_q <= W'(op_a_i[H-1:0]) * W'(op_b_i[H-1:0]);
    pp01_q <= W'(op_a_i[H-1:0]) * W'(op_b_i[W-1:H]);
    pp10_q <= W'(op_a_i[W-1:H]) * W'(op_b_i[H-1:0]);
    pp11_q <= W'(op_a_i[W-1:H]) * W'(op_b_i[W-1:H]);
  end

  // stage two: align and sum
  always_ff @(posedge clk_i) begin
    prod_q <= P'(pp00_q) + (P'(pp01_q) << H) + (P'(pp10_q) << H) + (P'(pp11_q) << W);
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// File: sv/mipb_dp.sv
`default_nettype none
module mipb_dp #(
  parameter int unsigned MODULUS_BITS = 61
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire mipb_pkg::cmd_t              cmd_i,
  output mipb_pkg::sts_t                   sts_o,
  input  wire logic [MODULUS_BITS-1:0]     left_value_i,
  input  wire logic [MODULUS_BITS-1:0]     right_value_i,
  input  wire logic                        last_pair_i,
  input  wire logic [MODULUS_BITS-1:0]     modulus_i,
  input  wire logic [mipb_pkg::WordW-1:0]  ratio_low_i,
  input  wire logic [mipb_pkg::WordW-1:0]  ratio_high_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [MODULUS_BITS-1:0]     dot_sum_o
);

  localparam int unsigned W = mipb_pkg::WordW;
  localparam int unsigned P = mipb_pkg::ProdW;
  localparam int unsigned M = MODULUS_BITS;

  logic [M-1:0] left_q, right_q;
  logic         last_q;
  logic [W-1:0] z0_q, z1_q, carry1_q, acc_q, upper_q, carry2_q, quot_q, rem_q;
  logic [M-1:0] red_q, run_q, dot_sum_q;
  logic         out_valid_q;

  logic [W-1:0] op_a, op_b, mod_w, rem_sub;
  logic [P-1:0] prod;
  logic [W-1:0] prod_lo, prod_hi;
  logic [W:0]   acc_sum, t_sum;
  logic [M:0]   run_sum, run_sub;
  logic [M-1:0] run_next;

  assign mod_w   = W'(modulus_i);
  assign prod_lo = prod[W-1:0];
  assign prod_hi = prod[P-1:W];

  always_comb begin
    case (cmd_i.mul_sel)
      mipb_pkg::MulAB: begin
        op_a = W'(left_q);
        op_b = W'(right_q);
      end
      mipb_pkg::MulZ0RatioLow: begin
        op_a = prod_lo;
        op_b = ratio_low_i;
      end
      mipb_pkg::MulZ0RatioHigh: begin
        op_a = z0_q;
        op_b = ratio_high_i;
      end
      mipb_pkg::MulZ1RatioLow: begin
        op_a = z1_q;
        op_b = ratio_low_i;
      end
      mipb_pkg::MulZ1RatioHigh: begin
        op_a = z1_q;
        op_b = ratio_high_i;
      end
      mipb_pkg::MulQuotMod: begin
        op_a = quot_q;
        op_b = mod_w;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  mipb_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  assign acc_sum  = {1'b0, prod_lo} + {1'b0, carry1_q};
  assign t_sum    = {1'b0, acc_q} + {1'b0, prod_lo};
  assign rem_sub  = rem_q - mod_w;
  assign run_sum  = {1'b0, run_q} + {1'b0, red_q};
  assign run_sub  = run_sum - {1'b0, modulus_i};
  assign run_next = (run_sum >= {1'b0, modulus_i}) ? run_sub[M-1:0] : run_sum[M-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      left_q  <= left_value_i;
      right_q <= right_value_i;
      last_q  <= last_pair_i;
    end
    if (cmd_i.cap_z) begin
      z0_q <= prod_lo;
      z1_q <= prod_hi;
    end
    if (cmd_i.cap_carry1) begin
      carry1_q <= prod_hi;
    end
    if (cmd_i.cap_acc) begin
      acc_q   <= acc_sum[W-1:0];
      upper_q <= prod_hi + W'(acc_sum[W]);
    end
    if (cmd_i.cap_carry2) begin
      carry2_q <= prod_hi + W'(t_sum[W]);
    end
    if (cmd_i.cap_quot) begin
      quot_q <= prod_lo + upper_q + carry2_q;
    end
    if (cmd_i.cap_rem) begin
      rem_q <= z0_q - prod_lo;
    end
    if (cmd_i.cap_red) begin
      red_q <= (rem_q >= mod_w) ? rem_sub[M-1:0] : rem_q[M-1:0];
    end
    if (cmd_i.acc_en && last_q) begin
      dot_sum_q <= run_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc_en) begin
        run_q <= last_q ? '0 : run_next;
      end
      if (cmd_i.acc_en && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.last     = last_q;
  assign sts_o.out_busy = out_valid_q & ~out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign dot_sum_o      = dot_sum_q;

endmodule
`default_nettype wire

// File: sv/mipb_ctrl.sv
`default_nettype none
module mipb_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire mipb_pkg::sts_t  sts_i,
  output mipb_pkg::cmd_t       cmd_o
);

  localparam logic [3:0] StIdle     = 4'd0;
  localparam logic [3:0] StMulAB    = 4'd1;
  localparam logic [3:0] StWaitAB   = 4'd2;
  localparam logic [3:0] StCapZ     = 4'd3;
  localparam logic [3:0] StMulZ0Hi  = 4'd4;
  localparam logic [3:0] StMulZ1Lo  = 4'd5;
  localparam logic [3:0] StMulZ1Hi  = 4'd6;
  localparam logic [3:0] StCarry    = 4'd7;
  localparam logic [3:0] StQuot     = 4'd8;
  localparam logic [3:0] StMulQ     = 4'd9;
  localparam logic [3:0] StWaitQ    = 4'd10;
  localparam logic [3:0] StRem      = 4'd11;
  localparam logic [3:0] StReduce   = 4'd12;
  localparam logic [3:0] StAccum    = 4'd13;

  logic [3:0] state_q, state_d;
  logic       acc_go;

  assign acc_go = ~(sts_i.last & sts_i.out_busy);

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = mipb_pkg::MulAB;
    state_d       = state_q;
    in_ready_o    = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = StMulAB;
        end
      end
      StMulAB: begin
        cmd_o.mul_sel = mipb_pkg::MulAB;
        state_d       = StWaitAB;
      end
      StWaitAB: begin
        state_d = StCapZ;
      end
      StCapZ: begin
        cmd_o.cap_z   = 1'b1;
        cmd_o.mul_sel = mipb_pkg::MulZ0RatioLow;
        state_d       = StMulZ0Hi;
      end
      StMulZ0Hi: begin
        cmd_o.mul_sel = mipb_pkg::MulZ0RatioHigh;
        state_d       = StMulZ1Lo;
      end
      StMulZ1Lo: begin
        cmd_o.mul_sel    = mipb_pkg::MulZ1RatioLow;
        cmd_o.cap_carry1 = 1'b1;
        state_d          = StMulZ1Hi;
      end
      StMulZ1Hi: begin
        cmd_o.mul_sel = mipb_pkg::MulZ1RatioHigh;
        cmd_o.cap_acc = 1'b1;
        state_d       = StCarry;
      end
      StCarry: begin
        cmd_o.cap_carry2 = 1'b1;
        state_d          = StQuot;
      end
      StQuot: begin
        cmd_o.cap_quot = 1'b1;
        state_d        = StMulQ;
      end
      StMulQ: begin
        cmd_o.mul_sel = mipb_pkg::MulQuotMod;
        state_d       = StWaitQ;
      end
      StWaitQ: begin
        state_d = StRem;
      end
      StRem: begin
        cmd_o.cap_rem = 1'b1;
        state_d       = StReduce;
      end
      StReduce: begin
        cmd_o.cap_red = 1'b1;
        state_d       = StAccum;
      end
      StAccum: begin
        // hold the last pair while a finished sum is still unclaimed
        cmd_o.acc_en = acc_go;
        if (acc_go) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/modular_inner_product_barrett_top.sv
// pairs: a new pair is accepted only after the previous one is finished; the two-stage 64x64 multiplier
//   is used six times per pair in dependent order
// reset: rst_ni clears the accumulator, the output valid and the controller;
//   modulus resets to 2 and both ratio words to 0
`default_nettype none
module modular_inner_product_barrett_top #(
  parameter int unsigned MODULUS_BITS = 61
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  mipb_in_if.sink                            in_i,
  mipb_out_if.source                         out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mipb_pkg::AddrW-1:0]    paddr,
  input  wire logic [mipb_pkg::WordW-1:0]    pwdata,
  output logic      [mipb_pkg::WordW-1:0]    prdata,
  output logic                               pready
);

  logic [MODULUS_BITS-1:0]     modulus;
  logic [mipb_pkg::WordW-1:0]  ratio_low, ratio_high;
  mipb_pkg::cmd_t              cmd;
  mipb_pkg::sts_t              sts;
  logic                        in_ready;
  logic                        out_valid;
  logic [MODULUS_BITS-1:0]     dot_sum;

  mipb_regs #(.MODULUS_BITS(MODULUS_BITS)) u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .modulus_o    (modulus),
    .ratio_low_o  (ratio_low),
    .ratio_high_o (ratio_high)
  );

  mipb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mipb_dp #(.MODULUS_BITS(MODULUS_BITS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .left_value_i  (in_i.left_value),
    .right_value_i (in_i.right_value),
    .last_pair_i   (in_i.last_pair),
    .modulus_i     (modulus),
    .ratio_low_i   (ratio_low),
    .ratio_high_i  (ratio_high),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_o.ready),
    .dot_sum_o     (dot_sum)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.dot_sum = dot_sum;

endmodule
`default_nettype wire

// File: sv/mipb_chk.sv
`default_nettype none
`include "assert_macros.svh"
module mipb_chk #(
  parameter int unsigned MODULUS_BITS = 61
) (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_i,
  input wire logic                    out_valid_i,
  input wire logic                    out_ready_i,
  input wire logic [MODULUS_BITS-1:0] dot_sum_i
);

  // an accepted item keeps the input closed while it is worked on
  `ASSERT_IMPL(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, ##1 !in_ready_i ##1 !in_ready_i, "input reopened too early")

  // a new sum only comes out of a busy cycle
  `ASSERT_IMPL(a_sum_from_busy, clk_i, rst_ni, $rose(out_valid_i), $past(!in_ready_i), "sum appeared while idle")

  `ASSERT_IMPL(a_out_valid_held, clk_i, rst_ni, out_valid_i && !out_ready_i, ##1 out_valid_i, "output valid dropped")

  `ASSERT_IMPL(a_out_data_held, clk_i, rst_ni, out_valid_i && !out_ready_i, ##1 $stable(dot_sum_i), "output data changed under stall")

endmodule

bind modular_inner_product_barrett_top mipb_chk #(.MODULUS_BITS(MODULUS_BITS)) u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .dot_sum_i   (out_o.dot_sum)
);
`default_nettype wire
